FILE: rtl/prd_pkg.sv
// Package for the peak/RMS decimator: constants and types.
`default_nettype none
package prd_pkg;
    localparam int MaxChannels     = 8;
    localparam int SampleBits      = 16;
    localparam int GroupsPerNotify = 64;
    localparam int CountBits       = 21;

    localparam logic [3:0]  ChannelCountReset = 4'd2;
    localparam logic [20:0] GroupSizeReset    = 21'd1024;

    typedef enum logic [0:0] {
        CFG_CHANNEL_COUNT = 1'b0,
        CFG_GROUP_SIZE    = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DIV,
        ST_ROOT,
        ST_EMIT,
        ST_CLEAR
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/prd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module prd_ram #(
    parameter int Width = 8,
    parameter int Depth = 8
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/peak_rms_decimator.sv
// Top level of the peak/RMS decimator: per-channel min, max and sum of squares in RAM.
//
// Channel     Direction  Word contents
// s_axis      in         tdata[15:0] sample
// m_axis      out        tdata channel, max_milli, min_milli, rms_milli; tlast; tuser notify
// cfg         in         index 0 channel_count, 1 samples_per_group
//
// Accumulation of a sample is a RAM read, then the write back.
// A closed group takes, per channel, a RAM read, a 53-step divide, the scaling
// multiply, a 37-step root and the output handshake, which the receiver can
// stall; the RAM sweep to reset values then takes one cycle per channel slot.
// No sample is accepted during that time. The RAM contents are cleared by the
// same sweep over all MaxChannels slots after reset as well.
`default_nettype none
module peak_rms_decimator #(
    parameter int MAX_CHANNELS      = prd_pkg::MaxChannels,
    parameter int SAMPLE_BITS       = prd_pkg::SampleBits,
    parameter int GROUPS_PER_NOTIFY = prd_pkg::GroupsPerNotify,
    parameter int COUNT_BITS        = prd_pkg::CountBits
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [15:0]  s_axis_tdata,   // [15:0] sample
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [2:0] channel, [13:3] max_milli,
                                        // [24:14] min_milli, [34:25] rms_milli
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] notify
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [0:0]   i_cfg_index,
    input  wire [20:0]  i_cfg_data
);
    localparam int SB = SAMPLE_BITS;
    localparam int ChBits = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SumBits = 2 * SB + COUNT_BITS;
    localparam int RamW = 2 * SB + SumBits;
    localparam int GcBits = (GROUPS_PER_NOTIFY > 1) ? $clog2(GROUPS_PER_NOTIFY + 1) : 1;
    // Even width so the root takes its bit pairs on even positions.
    localparam int ProdBits = ((SumBits + 21) / 2) * 2;
    localparam int RootBits = (ProdBits + 1) / 2;
    localparam int DivCntBits = $clog2(SumBits + 1);
    localparam int RootCntBits = $clog2(RootBits + 1);
    localparam logic signed [SB-1:0] PeakHighReset = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] PeakLowReset  = {1'b0, {(SB-1){1'b1}}};
    localparam int RecipShift = COUNT_BITS + ChBits;

    prd_pkg::t_state r_state, n_state;
    logic [3:0]  r_chan_cfg;
    logic [20:0] r_group_size;
    logic [COUNT_BITS-1:0] r_count;
    logic [ChBits-1:0] r_ch;
    logic [GcBits-1:0] r_group_cnt;
    logic r_notify;
    logic [ChBits:0] r_chans;  // effective channel count

    // accumulate pipeline
    logic r_acc_v;
    logic signed [SB-1:0] r_acc_s;
    logic [ChBits-1:0] r_acc_ch;

    // ram
    logic ram_we;
    logic [ChBits-1:0] ram_waddr, ram_raddr;
    logic [RamW-1:0] ram_wdata, ram_rdata;

    // group processing
    logic [ChBits-1:0] r_oc;
    logic [ChBits:0] r_clr;
    logic [1:0] r_rd_pend;
    logic signed [SB-1:0] r_hi, r_lo;
    logic [SumBits-1:0] r_quo, r_rem_src;
    logic [COUNT_BITS-1:0] r_n;
    logic [COUNT_BITS:0] r_drem;
    logic [DivCntBits-1:0] r_dcnt;
    logic [ProdBits-1:0] r_rv;
    logic [RootBits:0] r_root;
    logic [RootBits+1:0] r_rrem;
    logic [RootCntBits-1:0] r_rcnt;
    logic r_group_pending;
    logic [COUNT_BITS-1:0] r_closed_count;
    logic [COUNT_BITS-1:0] n_div_calc;

    prd_ram #(.Width(RamW), .Depth(MAX_CHANNELS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    always_comb begin
        if (r_chan_cfg == 4'd0) r_chans = (ChBits+1)'(1);
        else if (32'(r_chan_cfg) > MAX_CHANNELS) r_chans = (ChBits+1)'(MAX_CHANNELS);
        else r_chans = (ChBits+1)'(r_chan_cfg);
    end

    logic s_fire, m_fire, acc_close;
    logic [ChBits-1:0] cur_ch, nxt_ch;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic signed [SB-1:0] old_hi, old_lo, new_hi, new_lo;
    logic [SumBits-1:0] old_sum, new_sum;
    logic [2*SB-1:0] sq;

    // No sample is accepted while the last one is written back, so the read is never overlapped.
    assign s_axis_tready = (r_state == prd_pkg::ST_RUN) && !r_acc_v;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        cur_ch = ((ChBits+1)'(r_ch) >= r_chans) ? '0 : r_ch;
        nxt_ch = ((ChBits+1)'(cur_ch) + 1'b1 >= r_chans) ? '0 : cur_ch + 1'b1;
        cnt_inc = r_count + 1'b1;
        acc_close = (21'(cnt_inc) >= r_group_size) || (COUNT_BITS > 21 &&
                    (cnt_inc >> 21) != 0);
        old_hi = ram_rdata[SB-1:0];
        old_lo = ram_rdata[2*SB-1:SB];
        old_sum = ram_rdata[RamW-1:2*SB];
        new_hi = (r_acc_s > old_hi) ? r_acc_s : old_hi;
        new_lo = (r_acc_s < old_lo) ? r_acc_s : old_lo;
        sq = (2*SB)'($signed(r_acc_s) * $signed(r_acc_s));
        new_sum = old_sum + SumBits'(sq);
    end

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = r_acc_ch;
        ram_wdata = {new_sum, new_lo, new_hi};
        ram_raddr = (r_state == prd_pkg::ST_RUN) ? cur_ch : r_oc;
        if (r_state == prd_pkg::ST_CLEAR) begin
            ram_we = 1'b1;
            ram_waddr = r_clr[ChBits-1:0];
            ram_wdata = {{SumBits{1'b0}}, PeakLowReset, PeakHighReset};
        end else if (r_acc_v) begin
            ram_we = 1'b1;
        end
    end

    logic div_done, root_done, emit_next_last;
    assign div_done = (r_dcnt == DivCntBits'(SumBits));
    assign root_done = (r_rcnt == RootCntBits'(RootBits));
    assign emit_next_last = ((ChBits+1)'(r_oc) + 1'b1 >= r_chans);

    always_comb begin
        n_state = r_state;
        case (r_state)
            prd_pkg::ST_RUN:   if (r_acc_v && r_count == '0 && r_group_pending)
                                   n_state = prd_pkg::ST_DIV;
            prd_pkg::ST_DIV:   if (r_rd_pend == 2'd0 && div_done)
                                   n_state = prd_pkg::ST_ROOT;
            prd_pkg::ST_ROOT:  if (root_done) n_state = prd_pkg::ST_EMIT;
            prd_pkg::ST_EMIT:  if (m_fire) n_state = emit_next_last ? prd_pkg::ST_CLEAR
                                                                    : prd_pkg::ST_DIV;
            prd_pkg::ST_CLEAR: if (r_clr == (ChBits+1)'(MAX_CHANNELS - 1))
                                   n_state = prd_pkg::ST_RUN;
            default:           n_state = prd_pkg::ST_RUN;
        endcase
    end

    // mean and root step values
    logic [COUNT_BITS:0] dshift;
    logic [RootBits+1:0] rtry;
    logic [RootBits+1:0] rcand;
    always_comb begin
        dshift = {r_drem[COUNT_BITS-1:0], r_rem_src[SumBits-1]};
        rcand = {r_rrem[RootBits-1:0], r_rv[ProdBits-1 -: 2]};
        rtry = {r_root[RootBits-1:0], 2'b01};
    end

    logic [RootBits:0] rms_full;
    logic [9:0] rms_out;
    logic signed [SB+10:0] hi_p, lo_p;
    logic signed [10:0] hi_m, lo_m;
    always_comb begin
        rms_full = r_root >> (SB - 1);
        rms_out = (r_n == '0) ? 10'd0 :
                  (rms_full > (RootBits+1)'(1000)) ? 10'd1000 : rms_full[9:0];
        hi_p = (SB+11)'(r_hi) * (SB+11)'(1000);
        lo_p = (SB+11)'(r_lo) * (SB+11)'(1000);
        hi_m = 11'((hi_p + ((hi_p < 0) ? (SB+11)'((1 << (SB-1)) - 1) : '0)) >>> (SB-1));
        lo_m = 11'((lo_p + ((lo_p < 0) ? (SB+11)'((1 << (SB-1)) - 1) : '0)) >>> (SB-1));
    end

    assign m_axis_tvalid = (r_state == prd_pkg::ST_EMIT);
    assign m_axis_tdata = {5'd0, rms_out, lo_m, hi_m, 3'(r_oc)};
    assign m_axis_tlast = emit_next_last;
    assign m_axis_tuser = r_notify;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prd_pkg::ST_CLEAR;
            r_chan_cfg <= prd_pkg::ChannelCountReset;
            r_group_size <= prd_pkg::GroupSizeReset;
            r_count <= '0;
            r_ch <= '0;
            r_group_cnt <= '0;
            r_notify <= 1'b0;
            r_acc_v <= 1'b0;
            r_oc <= '0;
            r_clr <= '0;
            r_rd_pend <= '0;
            r_group_pending <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (prd_pkg::t_cfg_index'(i_cfg_index))
                    prd_pkg::CFG_CHANNEL_COUNT: r_chan_cfg <= i_cfg_data[3:0];
                    prd_pkg::CFG_GROUP_SIZE:    r_group_size <= i_cfg_data;
                    default: ;
                endcase
            end
            r_acc_v <= s_fire;
            if (s_fire) begin
                r_acc_s <= $signed(s_axis_tdata[SB-1:0]);
                r_acc_ch <= cur_ch;
                r_ch <= nxt_ch;
                if (acc_close) begin
                    r_closed_count <= cnt_inc;
                    r_count <= '0;
                    r_group_pending <= 1'b1;
                    if (32'(r_group_cnt) + 1 >= GROUPS_PER_NOTIFY) begin
                        r_group_cnt <= '0;
                        r_notify <= 1'b1;
                    end else begin
                        r_group_cnt <= r_group_cnt + 1'b1;
                        r_notify <= 1'b0;
                    end
                end else begin
                    r_count <= cnt_inc;
                end
            end
            if (r_state == prd_pkg::ST_RUN && n_state == prd_pkg::ST_DIV) begin
                r_group_pending <= 1'b0;
                r_oc <= '0;
                r_rd_pend <= 2'd2;
                r_n <= COUNT_BITS'(n_div_calc);
            end
            case (r_state)
                prd_pkg::ST_DIV: begin
                    // The read is issued while r_rd_pend is 2; the word is captured while it is 1.
                    if (r_rd_pend == 2'd2) begin
                        r_rd_pend <= 2'd1;
                    end else if (r_rd_pend == 2'd1) begin
                        r_rd_pend <= 2'd0;
                        r_hi <= old_hi;
                        r_lo <= old_lo;
                        r_rem_src <= old_sum;
                        r_quo <= '0;
                        r_drem <= '0;
                        r_dcnt <= '0;
                    end else if (!div_done) begin
                        r_dcnt <= r_dcnt + 1'b1;
                        r_rem_src <= r_rem_src << 1;
                        if (r_n != '0 && dshift >= {1'b0, r_n}) begin
                            r_drem <= dshift - {1'b0, r_n};
                            r_quo <= {r_quo[SumBits-2:0], 1'b1};
                        end else begin
                            r_drem <= dshift;
                            r_quo <= {r_quo[SumBits-2:0], 1'b0};
                        end
                    end else begin
                        r_rv <= ProdBits'(r_quo) * ProdBits'(1000000);
                        r_root <= '0;
                        r_rrem <= '0;
                        r_rcnt <= '0;
                    end
                end
                prd_pkg::ST_ROOT: if (!root_done) begin
                    r_rcnt <= r_rcnt + 1'b1;
                    r_rv <= r_rv << 2;
                    if (rcand >= rtry) begin
                        r_rrem <= rcand - rtry;
                        r_root <= {r_root[RootBits-1:0], 1'b1};
                    end else begin
                        r_rrem <= rcand;
                        r_root <= {r_root[RootBits-1:0], 1'b0};
                    end
                end
                prd_pkg::ST_EMIT: if (m_fire) begin
                    r_clr <= '0;
                    if (!emit_next_last) begin
                        r_oc <= r_oc + 1'b1;
                        r_rd_pend <= 2'd2;
                    end
                end
                prd_pkg::ST_CLEAR: r_clr <= r_clr + 1'b1;
                default: ;
            endcase
        end
    end

    // Mean divisor: the closed count over the channel count, taken as a product
    // with a rounded-up reciprocal that is exact over the whole count range.
    logic [RecipShift:0] recip_tab [MAX_CHANNELS+1];
    logic [COUNT_BITS+RecipShift:0] n_prod;
    assign recip_tab[0] = '0;
    for (genvar d = 1; d <= MAX_CHANNELS; d++) begin : g_recip
        assign recip_tab[d] =
            (RecipShift+1)'(((64'd1 << RecipShift) + 64'(d) - 64'd1) / 64'(d));
    end
    always_comb begin
        n_prod = (COUNT_BITS+RecipShift+1)'(r_closed_count)
                 * (COUNT_BITS+RecipShift+1)'(recip_tab[r_chans]);
        n_div_calc = n_prod[RecipShift +: COUNT_BITS];
    end
endmodule
`default_nettype wire

FILE: tb/peak_rms_decimator_tb.sv
// Self-checking testbench for the peak/RMS decimator with a built-in group predictor.
module peak_rms_decimator_tb;
    localparam int HalfPeriod = 6;
    localparam int QuietCycles = 40;
    localparam int CycleLimit = 3000000;

    typedef enum logic [1:0] {OP_SAMPLE, OP_CFG, OP_DRAIN} t_op_kind;

    typedef struct {
        t_op_kind             kind;
        prd_pkg::t_cfg_index  idx;
        logic [20:0]          value;
    } t_stim_op;

    typedef struct packed {
        logic [2:0]  channel;
        logic [10:0] max_milli;
        logic [10:0] min_milli;
        logic [9:0]  rms_milli;
        logic        last;
        logic        notify;
    } t_summary;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [39:0] m_axis_tdata;
    wire         m_axis_tlast;
    wire         m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    wire         o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [20:0] i_cfg_data = '0;

    peak_rms_decimator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #HalfPeriod i_clk = ~i_clk;

    t_stim_op pending_ops[$];
    t_summary expected_summaries[$];
    int       mismatches = 0;
    int       quiet_count = 0;
    int       cycle_count = 0;
    logic     in_taken = 1'b0;

    // Predictor copy of the block's registers and stores.
    logic [3:0]  chan_reg;
    logic [20:0] group_reg;
    longint      peak_hi[prd_pkg::MaxChannels];
    longint      peak_lo[prd_pkg::MaxChannels];
    longint unsigned sq_sum[prd_pkg::MaxChannels];
    logic [20:0] sample_cnt;
    int unsigned chan_idx;
    int unsigned group_cnt;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [10:0] milli_of(longint v);
        longint m;
        m = (v * 1000) / 32768;
        return m[10:0];
    endfunction

    function automatic void clear_stores();
        for (int c = 0; c < prd_pkg::MaxChannels; c++) begin
            peak_hi[c] = -32768;
            peak_lo[c] = 32767;
            sq_sum[c] = 0;
        end
    endfunction

    function automatic void accumulate_sample(logic signed [15:0] smp);
        int unsigned chans;
        int unsigned ch;
        longint s;
        longint unsigned n;
        longint unsigned rms;
        logic notify;
        t_summary r;
        chans = chan_reg;
        if (chans == 0) chans = 1;
        if (chans > prd_pkg::MaxChannels) chans = prd_pkg::MaxChannels;
        s = smp;
        ch = (chan_idx >= chans) ? 0 : chan_idx;
        if (s > peak_hi[ch]) peak_hi[ch] = s;
        if (s < peak_lo[ch]) peak_lo[ch] = s;
        sq_sum[ch] += longint'(s * s);
        chan_idx = (ch + 1 >= chans) ? 0 : ch + 1;
        sample_cnt = sample_cnt + 1'b1;
        if (sample_cnt < group_reg) return;
        group_cnt++;
        notify = 1'b0;
        if (group_cnt >= prd_pkg::GroupsPerNotify) begin
            group_cnt = 0;
            notify = 1'b1;
        end
        n = sample_cnt / chans;
        for (int c = 0; c < chans; c++) begin
            rms = 0;
            if (n != 0) begin
                rms = int_sqrt((sq_sum[c] / n) * 64'd1000000) >> 15;
                if (rms > 1000) rms = 1000;
            end
            r.channel = c[2:0];
            r.max_milli = milli_of(peak_hi[c]);
            r.min_milli = milli_of(peak_lo[c]);
            r.rms_milli = rms[9:0];
            r.last = (c + 1 == chans);
            r.notify = notify;
            expected_summaries.push_back(r);
        end
        clear_stores();
        sample_cnt = '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at cycle %0d",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    task automatic put_sample(input logic [15:0] s);
        pending_ops.push_back('{OP_SAMPLE, prd_pkg::CFG_CHANNEL_COUNT, {5'd0, s}});
    endtask

    task automatic put_cfg(input prd_pkg::t_cfg_index idx, input logic [20:0] v);
        pending_ops.push_back('{OP_CFG, idx, v});
    endtask

    task automatic put_drain();
        pending_ops.push_back('{OP_DRAIN, prd_pkg::CFG_CHANNEL_COUNT, '0});
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    // Monitor and predictor update at the rising edge.
    always @(posedge i_clk) begin
        t_summary want;
        if (i_rst_n) begin
            cycle_count++;
            quiet_count++;
            in_taken = s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                accumulate_sample(s_axis_tdata);
                void'(pending_ops.pop_front());
                quiet_count = 0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == prd_pkg::CFG_CHANNEL_COUNT) chan_reg = i_cfg_data[3:0];
                else group_reg = i_cfg_data;
                void'(pending_ops.pop_front());
            end
            if (m_axis_tvalid && m_axis_tready) begin
                quiet_count = 0;
                if (expected_summaries.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata[31:0], 0);
                end else begin
                    want = expected_summaries.pop_front();
                    if (m_axis_tdata[2:0] != want.channel)
                        report_mismatch("channel", m_axis_tdata[2:0], want.channel);
                    if (m_axis_tdata[13:3] != want.max_milli)
                        report_mismatch("max_milli", m_axis_tdata[13:3], want.max_milli);
                    if (m_axis_tdata[24:14] != want.min_milli)
                        report_mismatch("min_milli", m_axis_tdata[24:14], want.min_milli);
                    if (m_axis_tdata[34:25] != want.rms_milli)
                        report_mismatch("rms_milli", m_axis_tdata[34:25], want.rms_milli);
                    if (m_axis_tlast != want.last)
                        report_mismatch("last", m_axis_tlast, want.last);
                    if (m_axis_tuser != want.notify)
                        report_mismatch("notify", m_axis_tuser, want.notify);
                end
            end
        end
    end

    // Driver: sample bursts, register writes only while idle, random receiver stalls.
    int   burst_left = 4;
    int   gap_left = 0;
    int   stall_mode = 0;
    int   stall_left = 0;
    logic idle_now;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            idle_now = (expected_summaries.size() == 0) && (quiet_count >= QuietCycles);
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(8, 48);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase

            if (pending_ops.size() != 0 && pending_ops[0].kind == OP_DRAIN && idle_now)
                void'(pending_ops.pop_front());

            i_cfg_valid <= (pending_ops.size() != 0) && pending_ops[0].kind == OP_CFG
                           && idle_now;
            if (pending_ops.size() != 0 && pending_ops[0].kind == OP_CFG) begin
                i_cfg_index <= pending_ops[0].idx;
                i_cfg_data <= pending_ops[0].value;
            end

            // A word already offered and not yet taken stays on the bus.
            if (!s_axis_tvalid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_ops.size() != 0 && pending_ops[0].kind == OP_SAMPLE)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_ops[0].value[15:0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CycleLimit) begin
            $display("peak_rms_decimator test failed");
            $finish;
        end
    end

    initial begin
        int chans;
        int gsize;
        int count;
        int random_items;
        chan_reg = prd_pkg::ChannelCountReset;
        group_reg = prd_pkg::GroupSizeReset;
        clear_stores();
        sample_cnt = '0;
        chan_idx = 0;
        group_cnt = 0;

        // Full-scale extremes on a single channel.
        put_cfg(prd_pkg::CFG_CHANNEL_COUNT, 21'd1);
        put_cfg(prd_pkg::CFG_GROUP_SIZE, 21'd4);
        put_sample(16'h7FFF);
        put_sample(16'h8000);
        put_sample(16'h0000);
        put_sample(16'hFFFF);
        // Group size zero closes a group on every sample.
        put_cfg(prd_pkg::CFG_GROUP_SIZE, 21'd0);
        put_sample(16'h0001);
        put_sample(16'h8000);
        // Channel count zero acts as one.
        put_cfg(prd_pkg::CFG_CHANNEL_COUNT, 21'd0);
        put_cfg(prd_pkg::CFG_GROUP_SIZE, 21'd1);
        put_sample(16'h3039);
        // Channel count above the maximum acts as eight.
        put_cfg(prd_pkg::CFG_CHANNEL_COUNT, 21'd15);
        put_cfg(prd_pkg::CFG_GROUP_SIZE, 21'd8);
        for (int i = 0; i < 8; i++) put_sample(i[0] ? 16'h8000 : 16'h7FFF);
        // Fewer samples than channels: zero rms, untouched channels at reset peaks.
        put_cfg(prd_pkg::CFG_GROUP_SIZE, 21'd3);
        for (int i = 0; i < 3; i++) put_sample(random_sample());
        // Leave a partial group behind under the largest sizes, then shrink the
        // channel count so the running index is out of range.
        put_cfg(prd_pkg::CFG_GROUP_SIZE, 21'h0FFFFF);
        put_cfg(prd_pkg::CFG_GROUP_SIZE, 21'h100000);
        for (int i = 0; i < 5; i++) put_sample(random_sample());
        put_cfg(prd_pkg::CFG_CHANNEL_COUNT, 21'd3);
        put_cfg(prd_pkg::CFG_GROUP_SIZE, 21'd6);
        put_sample(16'h1234);
        // Uneven split lets one channel exceed the mean, saturating rms.
        put_cfg(prd_pkg::CFG_CHANNEL_COUNT, 21'd2);
        put_cfg(prd_pkg::CFG_GROUP_SIZE, 21'd5);
        for (int i = 0; i < 5; i++) put_sample(16'h8000);

        random_items = 0;
        while (random_items < 215) begin
            chans = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            gsize = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 24);
            if ($urandom_range(0, 1) == 1) begin
                put_cfg(prd_pkg::CFG_CHANNEL_COUNT, 21'(chans));
                put_cfg(prd_pkg::CFG_GROUP_SIZE, 21'(gsize));
            end else begin
                put_cfg(prd_pkg::CFG_GROUP_SIZE, 21'(gsize));
                put_cfg(prd_pkg::CFG_CHANNEL_COUNT, 21'(chans));
            end
            // Mostly whole groups, sometimes a ragged tail.
            count = (gsize == 0 ? 1 : gsize) * $urandom_range(1, 4) + $urandom_range(0, 2);
            for (int i = 0; i < count; i++) put_sample(random_sample());
            random_items += count;
            if ($urandom_range(0, 3) == 0) put_drain();
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0);
        wait (expected_summaries.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_summaries.size() == 0) begin
            $display("peak_rms_decimator test passed");
        end else begin
            $display("peak_rms_decimator test failed");
        end
        $finish;
    end
endmodule
